### hw/rtl/fatc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fatc_pkg
// Types, name tables and match helpers shared by the axis type classifier.
// ----------------------------------------------------------------------------
package fatc_pkg;

   localparam int NUM_NAMES    = 20;
   localparam int NUM_PROJ     = 10;
   localparam int NUM_VEL      = 4;
   localparam int NAME_IDX_W   = 5;
   localparam int PROJ_IDX_W   = 4;
   localparam int VEL_IDX_W    = 2;
   localparam int POS_W        = 4;

   // token position saturates here; every table entry is shorter
   localparam logic [POS_W-1:0] POS_SAT = 4'd8;

   localparam logic [NAME_IDX_W-1:0] IDX_NUM_SKY = 5'd8;
   localparam logic [NAME_IDX_W-1:0] IDX_FREQ    = 5'd8;
   localparam logic [NAME_IDX_W-1:0] IDX_VELO    = 5'd9;
   localparam logic [NAME_IDX_W-1:0] IDX_PARAM   = 5'd15;
   localparam logic [NAME_IDX_W-1:0] KIND_OFFSET = 5'd5;

   localparam logic [3:0] KIND_NONE = 4'd0;
   localparam logic [3:0] KIND_LON  = 4'd1;
   localparam logic [3:0] KIND_LAT  = 4'd2;
   localparam logic [3:0] KIND_FREQ = 4'd3;
   localparam logic [3:0] KIND_VELO = 4'd4;

   localparam logic [3:0] PROJ_NONE     = 4'd0;
   localparam logic [3:0] PROJ_GNOMONIC = 4'd4;
   localparam logic [2:0] SKY_NONE      = 3'd0;
   localparam logic [1:0] VEL_NONE      = 2'd0;
   localparam logic [1:0] VEL_OPTICAL   = 2'd1;
   localparam logic [1:0] VEL_RADIO     = 2'd2;

   localparam logic [55:0] UNIT7_BLANK = 56'h20202020202020;
   localparam logic [23:0] UNIT3_BLANK = 24'h202020;
   localparam logic [23:0] UNIT3_MS    = "M/S";

   // entries are left justified, zero padded
   localparam logic [63:0] AXIS_NAMES [NUM_NAMES] = '{
      {"RA", 48'h0}, {"DEC", 40'h0}, {"GLON", 32'h0}, {"GLAT", 32'h0},
      {"ELON", 32'h0}, {"ELAT", 32'h0}, {"SLON", 32'h0}, {"SLAT", 32'h0},
      {"FREQ", 32'h0}, {"VELO", 32'h0}, {"LAMBDA", 16'h0}, {"INVLAM", 16'h0},
      {"LOGLAM", 16'h0}, {"TIME", 32'h0}, {"POLN", 32'h0}, {"PARAM", 24'h0},
      {"SAMPLE", 16'h0}, {"TICK", 32'h0}, {"SDET", 32'h0}, {"SNIP", 32'h0}
   };

   localparam logic [55:0] NATURAL_UNITS [NUM_NAMES] = '{
      {"DEGREE", 8'h20}, {"DEGREE", 8'h20}, {"DEGREE", 8'h20}, {"DEGREE", 8'h20},
      {"DEGREE", 8'h20}, {"DEGREE", 8'h20}, {"DEGREE", 8'h20}, {"DEGREE", 8'h20},
      {"HZ", 40'h2020202020}, {"M/S", 32'h20202020}, {"METER", 16'h2020},
      56'("1/METER"), {"LOG(M)", 8'h20}, {"SECOND", 8'h20}, UNIT7_BLANK,
      {"PAR", 32'h20202020}, {"TICK", 24'h202020}, {"TICK", 24'h202020},
      UNIT7_BLANK, UNIT7_BLANK
   };

   localparam logic [63:0] PROJ_NAMES [NUM_PROJ] = '{
      {"AIT", 40'h0}, {"CYL", 40'h0}, {"FLT", 40'h0}, {"TAN", 40'h0},
      {"SIN", 40'h0}, {"ARC", 40'h0}, {"GLS", 40'h0}, {"NCP", 40'h0},
      {"STG", 40'h0}, {"MER", 40'h0}
   };

   localparam logic [63:0] VEL_NAMES [NUM_VEL] = '{
      {"OLSR", 32'h0}, {"RLSR", 32'h0}, {"OHEL", 32'h0}, {"RHEL", 32'h0}
   };

   localparam logic [1:0] VEL_CODES [NUM_VEL] = '{
      VEL_OPTICAL, VEL_RADIO, VEL_OPTICAL, VEL_RADIO
   };

   // scanner state as seen after the current character
   typedef struct packed {
      logic                 first_seen;
      logic                 second_seen;
      logic [NUM_NAMES-1:0] name_mask;
      logic [NUM_PROJ-1:0]  proj_mask;
      logic [NUM_VEL-1:0]   vel_mask;
   } scan_view_type;

   typedef struct packed {
      logic [3:0]  axis_kind;
      logic [2:0]  sky_system;
      logic [3:0]  projection_code;
      logic [1:0]  velocity_system;
      logic [55:0] natural_unit;
      logic [23:0] secondary_unit;
   } result_type;

   // ch matches the entry at pos while the entry still has characters there
   function automatic logic char_fits(logic [63:0] entry, logic [POS_W-1:0] pos,
                                      logic [7:0] ch);
      logic [7:0] b;
      b = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (pos == POS_W'(k)) begin
            b = entry[63-8*k -: 8];
         end
      end
      return (b != 8'h00) && (b == ch);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/fatc_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fatc_scan
// Per-character token scanner: phase, counters and prefix match masks.
// ----------------------------------------------------------------------------
module fatc_scan #(
   parameter int MAX_NAME_CHARS = 80
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             char_code,
   input  wire logic                   last_char,
   output fatc_pkg::scan_view_type     view
);

   localparam int CNT_W = $clog2(MAX_NAME_CHARS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NAME_CHARS);

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SKIP   = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7a;
   localparam logic [7:0] CASE_OFS = 8'h20;

   logic [1:0]                       phase_ff, phase_in, phase_nx;
   logic [CNT_W-1:0]                 count_ff, count_in, count_nx;
   logic [fatc_pkg::POS_W-1:0]       first_len_ff, first_len_in, first_len_nx;
   logic [fatc_pkg::POS_W-1:0]       second_len_ff, second_len_in, second_len_nx;
   logic [fatc_pkg::NUM_NAMES-1:0]   name_mask_ff, name_mask_in, name_mask_nx;
   logic [fatc_pkg::NUM_PROJ-1:0]    proj_mask_ff, proj_mask_in, proj_mask_nx;
   logic [fatc_pkg::NUM_VEL-1:0]     vel_mask_ff, vel_mask_in, vel_mask_nx;
   logic [7:0]                       ch;
   logic                             do_first;
   logic                             do_second;

   always_comb begin
      ch = char_code;
      if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
         ch = ch - CASE_OFS;
      end

      phase_nx      = phase_ff;
      count_nx      = count_ff;
      first_len_nx  = first_len_ff;
      second_len_nx = second_len_ff;
      name_mask_nx  = name_mask_ff;
      proj_mask_nx  = proj_mask_ff;
      vel_mask_nx   = vel_mask_ff;
      do_first      = 1'b0;
      do_second     = 1'b0;

      if (step && count_ff < CNT_MAX && phase_ff != PH_DONE) begin
         count_nx = count_ff + CNT_W'(1);
         if (ch == CH_NUL) begin
            phase_nx = PH_DONE;
         end else begin
            unique case (phase_ff)
               PH_FIRST: begin
                  priority if (ch == CH_SPACE) phase_nx = PH_DONE;
                  else if (ch == CH_DASH) phase_nx = PH_SKIP;
                  else do_first = 1'b1;
               end
               PH_SKIP: begin
                  priority if (ch == CH_DASH) phase_nx = PH_SKIP;
                  else if (ch == CH_SPACE) phase_nx = PH_DONE;
                  else begin
                     phase_nx  = PH_SECOND;
                     do_second = 1'b1;
                  end
               end
               PH_SECOND: begin
                  if (ch == CH_SPACE || ch == CH_DASH) phase_nx = PH_DONE;
                  else do_second = 1'b1;
               end
               PH_DONE: begin
                  phase_nx = PH_DONE;
               end
            endcase
         end
      end

      if (do_first) begin
         for (int j = 0; j < fatc_pkg::NUM_NAMES; j++) begin
            if (!fatc_pkg::char_fits(fatc_pkg::AXIS_NAMES[j], first_len_ff, ch)) begin
               name_mask_nx[j] = 1'b0;
            end
         end
         if (first_len_ff != fatc_pkg::POS_SAT) begin
            first_len_nx = first_len_ff + fatc_pkg::POS_W'(1);
         end
      end

      if (do_second) begin
         for (int j = 0; j < fatc_pkg::NUM_PROJ; j++) begin
            if (!fatc_pkg::char_fits(fatc_pkg::PROJ_NAMES[j], second_len_ff, ch)) begin
               proj_mask_nx[j] = 1'b0;
            end
         end
         for (int j = 0; j < fatc_pkg::NUM_VEL; j++) begin
            if (!fatc_pkg::char_fits(fatc_pkg::VEL_NAMES[j], second_len_ff, ch)) begin
               vel_mask_nx[j] = 1'b0;
            end
         end
         if (second_len_ff != fatc_pkg::POS_SAT) begin
            second_len_nx = second_len_ff + fatc_pkg::POS_W'(1);
         end
      end
   end

   assign view.first_seen  = (first_len_nx != '0);
   assign view.second_seen = (second_len_nx != '0);
   assign view.name_mask   = name_mask_nx;
   assign view.proj_mask   = proj_mask_nx;
   assign view.vel_mask    = vel_mask_nx;

   // the last character of a name rearms the scanner for the next one
   always_comb begin
      if (step && last_char) begin
         phase_in      = PH_FIRST;
         count_in      = '0;
         first_len_in  = '0;
         second_len_in = '0;
         name_mask_in  = '1;
         proj_mask_in  = '1;
         vel_mask_in   = '1;
      end else begin
         phase_in      = phase_nx;
         count_in      = count_nx;
         first_len_in  = first_len_nx;
         second_len_in = second_len_nx;
         name_mask_in  = name_mask_nx;
         proj_mask_in  = proj_mask_nx;
         vel_mask_in   = vel_mask_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         count_ff      <= '0;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         name_mask_ff  <= '1;
         proj_mask_ff  <= '1;
         vel_mask_ff   <= '1;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         name_mask_ff  <= name_mask_in;
         proj_mask_ff  <= proj_mask_in;
         vel_mask_ff   <= vel_mask_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/fatc_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fatc_decode
// Turns the final match masks of a name into axis kind, codes and units.
// ----------------------------------------------------------------------------
module fatc_decode (
   input  wire fatc_pkg::scan_view_type view,
   output fatc_pkg::result_type         result
);

   logic [fatc_pkg::NAME_IDX_W-1:0] n;
   logic [fatc_pkg::NAME_IDX_W-1:0] kind_wide;
   logic [fatc_pkg::PROJ_IDX_W-1:0] p;
   logic                            p_hit;
   logic [fatc_pkg::VEL_IDX_W-1:0]  v;
   logic                            v_hit;

   // lowest set bit wins
   always_comb begin
      n = fatc_pkg::IDX_PARAM;
      for (int j = fatc_pkg::NUM_NAMES - 1; j >= 0; j--) begin
         if (view.name_mask[j]) n = fatc_pkg::NAME_IDX_W'(j);
      end
      p     = '0;
      p_hit = 1'b0;
      for (int j = fatc_pkg::NUM_PROJ - 1; j >= 0; j--) begin
         if (view.proj_mask[j]) begin
            p     = fatc_pkg::PROJ_IDX_W'(j);
            p_hit = 1'b1;
         end
      end
      v     = '0;
      v_hit = 1'b0;
      for (int j = fatc_pkg::NUM_VEL - 1; j >= 0; j--) begin
         if (view.vel_mask[j]) begin
            v     = fatc_pkg::VEL_IDX_W'(j);
            v_hit = 1'b1;
         end
      end
   end

   assign kind_wide = n - fatc_pkg::KIND_OFFSET;

   always_comb begin
      result.axis_kind       = fatc_pkg::KIND_NONE;
      result.sky_system      = fatc_pkg::SKY_NONE;
      result.projection_code = fatc_pkg::PROJ_NONE;
      result.velocity_system = fatc_pkg::VEL_NONE;
      result.natural_unit    = fatc_pkg::UNIT7_BLANK;
      result.secondary_unit  = fatc_pkg::UNIT3_BLANK;
      if (view.first_seen) begin
         result.natural_unit = fatc_pkg::NATURAL_UNITS[n];
         if (n == fatc_pkg::IDX_FREQ) result.secondary_unit = fatc_pkg::UNIT3_MS;
         if (n < fatc_pkg::IDX_NUM_SKY) begin
            // sky axes come in longitude/latitude pairs
            result.axis_kind  = n[0] ? fatc_pkg::KIND_LAT : fatc_pkg::KIND_LON;
            result.sky_system = 3'(n[2:1]) + 3'd1;
            if (view.second_seen && p_hit) begin
               result.projection_code = 4'(p) + 4'd1;
            end else begin
               result.projection_code = fatc_pkg::PROJ_GNOMONIC;
            end
         end else begin
            result.axis_kind = kind_wide[3:0];
            if (n == fatc_pkg::IDX_FREQ && view.second_seen && v_hit) begin
               result.velocity_system = fatc_pkg::VEL_CODES[v];
            end else if (n == fatc_pkg::IDX_VELO) begin
               result.velocity_system = fatc_pkg::VEL_RADIO;
            end
         end
      end
   end

endmodule
`default_nettype wire

### hw/rtl/fits_axis_type_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fits_axis_type_classifier_core
// Classifies an axis name streamed one character per item into axis kind,
// sky system, projection, velocity system and unit strings.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_char_code, req_last_char
//  rsp      out  rsp_valid/rsp_ready  rsp_axis_kind .. rsp_secondary_unit
//
// one character per cycle unless a last character waits on a held result;
// the edge that accepts the last character of a name loads the input register,
// and the result register loads as that character leaves it, raising rsp_valid;
// the scanner match masks and the decode sit between the two registers.
// reset is synchronous and rearms the scanner; no clearing pass.
// a last character waits in the input register only while a result is
// held by rsp_ready low; other characters keep flowing.
// ----------------------------------------------------------------------------
module fits_axis_type_classifier_core #(
   parameter int MAX_NAME_CHARS = 80
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_axis_kind,
   output logic [2:0]       rsp_sky_system,
   output logic [3:0]       rsp_projection_code,
   output logic [1:0]       rsp_velocity_system,
   output logic [55:0]      rsp_natural_unit,
   output logic [23:0]      rsp_secondary_unit
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_char_ff;
   logic                    in_last_ff;
   logic                    out_valid_ff, out_valid_in;
   fatc_pkg::result_type    out_data_ff;
   fatc_pkg::result_type    result;
   fatc_pkg::scan_view_type view;
   logic                    out_free;
   logic                    step;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || step;

   fatc_scan #(
      .MAX_NAME_CHARS(MAX_NAME_CHARS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .view      (view)
   );

   fatc_decode u_decode (
      .view   (view),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (step && in_last_ff) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
      if (step && in_last_ff) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_axis_kind       = out_data_ff.axis_kind;
   assign rsp_sky_system      = out_data_ff.sky_system;
   assign rsp_projection_code = out_data_ff.projection_code;
   assign rsp_velocity_system = out_data_ff.velocity_system;
   assign rsp_natural_unit    = out_data_ff.natural_unit;
   assign rsp_secondary_unit  = out_data_ff.secondary_unit;

   // only a waiting last character may hold off the input side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_last_ff && out_valid_ff && !rsp_ready)
      else $error("input stalled without a held result");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_axis_kind == fatc_pkg::KIND_NONE |->
         rsp_sky_system == fatc_pkg::SKY_NONE &&
         rsp_projection_code == fatc_pkg::PROJ_NONE &&
         rsp_velocity_system == fatc_pkg::VEL_NONE)
      else $error("empty name with nonzero codes");

   a_sky_proj: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (rsp_axis_kind == fatc_pkg::KIND_LON ||
                       rsp_axis_kind == fatc_pkg::KIND_LAT) |->
         rsp_sky_system != fatc_pkg::SKY_NONE &&
         rsp_projection_code != fatc_pkg::PROJ_NONE)
      else $error("sky axis without system or projection");

   a_velo_radio: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_axis_kind == fatc_pkg::KIND_VELO |->
         rsp_velocity_system == fatc_pkg::VEL_RADIO)
      else $error("velocity axis not radio");

endmodule
`default_nettype wire
